// File: rtl/assert_macros.svh
// Assertion helpers for the RTL modules (included by pictl_fsm).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/pictl_pkg.sv
package pictl_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ByteIdxW = 4;

  // datapath commands
  localparam logic [2:0] OP_IDLE = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_MP   = 3'd2;
  localparam logic [2:0] OP_MI   = 3'd3;
  localparam logic [2:0] OP_DRV  = 3'd4;
  localparam logic [2:0] OP_MS   = 3'd5;
  localparam logic [2:0] OP_DUTY = 3'd6;
  localparam logic [2:0] OP_EMIT = 3'd7;

  // config register indexes
  localparam logic [CfgIdxW-1:0] REG_PROP_MULT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PROP_SHIFT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INTEG_MULT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEG_SHIFT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCALE_MULT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCALE_SHIFT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_REPORT_MODE = 3'd6;

  // report modes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_A      = 3'd1;
  localparam logic [2:0] MODE_B      = 3'd2;
  localparam logic [2:0] MODE_INTEG  = 3'd3;
  localparam logic [2:0] MODE_ERR    = 3'd4;
  localparam logic [2:0] MODE_DRIVE  = 3'd5;
  localparam logic [2:0] MODE_DUTY   = 3'd6;
  localparam logic [2:0] MODE_PACKET = 3'd7;

  localparam logic [7:0]          PKT_HDR      = 8'd103;
  localparam logic [ByteIdxW-1:0] PKT_LAST_IDX = 4'd10;
  localparam logic [ByteIdxW-1:0] PKT_IDX_A    = 4'd1;
  localparam logic [ByteIdxW-1:0] PKT_IDX_B    = 4'd2;
  localparam logic [ByteIdxW-1:0] PKT_IDX_EHI  = 4'd3;
  localparam logic [ByteIdxW-1:0] PKT_IDX_ELO  = 4'd4;
  localparam logic [ByteIdxW-1:0] PKT_IDX_IHI  = 4'd5;
  localparam logic [ByteIdxW-1:0] PKT_IDX_ILO  = 4'd6;
  localparam logic [ByteIdxW-1:0] PKT_IDX_DHI  = 4'd7;
  localparam logic [ByteIdxW-1:0] PKT_IDX_DLO  = 4'd8;
  localparam logic [ByteIdxW-1:0] PKT_IDX_DUTY = 4'd9;

  typedef struct packed {
    logic [2:0]          op;
    logic [ByteIdxW-1:0] byte_idx;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
  } stat_t;

endpackage

// File: rtl/pictl_in_if.sv
interface pictl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_a;
  logic [7:0] sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

// File: rtl/pictl_out_if.sv
interface pictl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic [7:0] report_byte;
  logic       has_report;
  logic       last;

  modport source (output valid, output duty, output report_byte, output has_report,
                  output last, input ready);
  modport sink   (input valid, input duty, input report_byte, input has_report,
                  input last, output ready);
endinterface

// File: rtl/pi_controller_with_report.sv
// Channel   Dir  Payload                                   Handshake
// in_chan   in   sample_a[8], sample_b[8]                  valid/ready
// out_chan  out  duty[8], report_byte[8], has_report, last valid/ready
// cfg_*     in   cfg_idx[3], cfg_wdata[16]                 cfg_we, no stall
//
// A request emits 1, 2 or 11 report bytes; after acceptance the FSM steps S_MP,
// S_MI, S_DRV, S_MS, S_DUTY, and out valid rises in S_EMIT. The three chained
// products share one multiplier, and bytes leave one per cycle.
// Reset (rst_n low, synchronous) clears the config regs, integral and FSM.
// out_ready low holds the current byte; in_chan.ready is high only when idle.
module pi_controller_with_report (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pictl_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [pictl_pkg::CfgDataW-1:0]  cfg_wdata,
  pictl_in_if.sink                        in_chan,
  pictl_out_if.source                     out_chan
);

  pictl_pkg::cmd_t  cmd;
  pictl_pkg::stat_t stat;
  logic             in_ready;
  logic             out_valid;

  pictl_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pictl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .sample_a    (in_chan.sample_a),
    .sample_b    (in_chan.sample_b),
    .cmd         (cmd),
    .stat        (stat),
    .duty        (out_chan.duty),
    .report_byte (out_chan.report_byte),
    .has_report  (out_chan.has_report),
    .last        (out_chan.last)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

// File: rtl/pictl_fsm.sv
`include "assert_macros.svh"

module pictl_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pictl_pkg::stat_t stat,
  output pictl_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MP   = 3'd1;
  localparam logic [2:0] S_MI   = 3'd2;
  localparam logic [2:0] S_DRV  = 3'd3;
  localparam logic [2:0] S_MS   = 3'd4;
  localparam logic [2:0] S_DUTY = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [pictl_pkg::ByteIdxW-1:0]  idx_r, idx_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd.op       = pictl_pkg::OP_IDLE;
    cmd.byte_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          cmd.op    = pictl_pkg::OP_LOAD;
          state_nxt = S_MP;
        end
      end
      S_MP: begin
        cmd.op    = pictl_pkg::OP_MP;
        state_nxt = S_MI;
      end
      S_MI: begin
        cmd.op    = pictl_pkg::OP_MI;
        state_nxt = S_DRV;
      end
      S_DRV: begin
        cmd.op    = pictl_pkg::OP_DRV;
        state_nxt = S_MS;
      end
      S_MS: begin
        cmd.op    = pictl_pkg::OP_MS;
        state_nxt = S_DUTY;
      end
      S_DUTY: begin
        cmd.op    = pictl_pkg::OP_DUTY;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op = pictl_pkg::OP_EMIT;
        if (out_ready) begin
          if (stat.last_byte) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
  `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_MP)
  `ASSERT_NEXT(a_last_ends, out_valid && out_ready && stat.last_byte, in_ready)
  `ASSERT_IMPL(a_idx_range, out_valid, idx_r <= pictl_pkg::PKT_LAST_IDX)

endmodule

// File: rtl/pictl_dp.sv
module pictl_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pictl_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [pictl_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic [7:0]                      sample_a,
  input  logic [7:0]                      sample_b,
  input  pictl_pkg::cmd_t                 cmd,
  output pictl_pkg::stat_t                stat,
  output logic [7:0]                      duty,
  output logic [7:0]                      report_byte,
  output logic                            has_report,
  output logic                            last
);

  function automatic logic signed [15:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sd32767;
    end else if (v < -34'sd32768) begin
      return -16'sd32768;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sd32767;
    end else if (v < -17'sd32768) begin
      return -16'sd32768;
    end else begin
      return v[15:0];
    end
  endfunction

  logic [15:0]        prop_mult_r, integ_mult_r, scale_mult_r;
  logic [4:0]         prop_shift_r, integ_shift_r, scale_shift_r;
  logic [2:0]         mode_r;
  logic signed [15:0] integ_r, integ_nxt;

  logic [7:0]         a_r, b_r;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [15:0] p_r, drive_r, drive_nxt;
  logic [7:0]         duty_r, duty_nxt;

  logic signed [8:0]  err;
  logic [15:0]        ue;
  logic signed [16:0] mul_x, mul_m;
  logic [4:0]         sh_amt;
  logic signed [15:0] sh_term, t;
  logic [15:0]        dsum;
  logic [15:0]        word;
  logic [pictl_pkg::ByteIdxW-1:0] last_idx;

  assign err = $signed({1'b0, b_r}) - $signed({1'b0, a_r});
  assign ue  = {{7{err[8]}}, err};

  always_comb begin
    unique case (cmd.op)
      pictl_pkg::OP_MI: begin
        mul_x = {integ_r[15], integ_r};
        mul_m = $signed({1'b0, integ_mult_r});
      end
      pictl_pkg::OP_MS: begin
        mul_x = {drive_r[15], drive_r};
        mul_m = $signed({1'b0, scale_mult_r});
      end
      default: begin
        mul_x = {{8{err[8]}}, err};
        mul_m = $signed({1'b0, prop_mult_r});
      end
    endcase
  end

  assign prod_nxt = 34'(mul_x) * 34'(mul_m);

  always_comb begin
    unique case (cmd.op)
      pictl_pkg::OP_DRV:  sh_amt = integ_shift_r;
      pictl_pkg::OP_DUTY: sh_amt = scale_shift_r;
      default:            sh_amt = prop_shift_r;
    endcase
  end

  assign sh_term   = sat34(prod_r >>> sh_amt);
  assign drive_nxt = sat17({p_r[15], p_r} + {sh_term[15], sh_term});
  assign integ_nxt = sat17({integ_r[15], integ_r} + {{8{err[8]}}, err});
  assign t         = sat17({sh_term[15], sh_term} + 17'sd32767);
  assign dsum      = t + 16'h7fff;
  assign duty_nxt  = dsum[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_mult_r   <= '0;
      prop_shift_r  <= '0;
      integ_mult_r  <= '0;
      integ_shift_r <= '0;
      scale_mult_r  <= '0;
      scale_shift_r <= '0;
      mode_r        <= pictl_pkg::MODE_NONE;
      integ_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          pictl_pkg::REG_PROP_MULT:   prop_mult_r   <= cfg_wdata;
          pictl_pkg::REG_PROP_SHIFT:  prop_shift_r  <= cfg_wdata[4:0];
          pictl_pkg::REG_INTEG_MULT:  integ_mult_r  <= cfg_wdata;
          pictl_pkg::REG_INTEG_SHIFT: integ_shift_r <= cfg_wdata[4:0];
          pictl_pkg::REG_SCALE_MULT:  scale_mult_r  <= cfg_wdata;
          pictl_pkg::REG_SCALE_SHIFT: scale_shift_r <= cfg_wdata[4:0];
          pictl_pkg::REG_REPORT_MODE: mode_r        <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      // integral updates after its term has been multiplied
      if (cmd.op == pictl_pkg::OP_MS) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pictl_pkg::OP_LOAD) begin
      a_r <= sample_a;
      b_r <= sample_b;
    end
    if (cmd.op == pictl_pkg::OP_MP || cmd.op == pictl_pkg::OP_MI ||
        cmd.op == pictl_pkg::OP_MS) begin
      prod_r <= prod_nxt;
    end
    if (cmd.op == pictl_pkg::OP_MI) begin
      p_r <= sh_term;
    end
    if (cmd.op == pictl_pkg::OP_DRV) begin
      drive_r <= drive_nxt;
    end
    if (cmd.op == pictl_pkg::OP_DUTY) begin
      duty_r <= duty_nxt;
    end
  end

  // report byte selection
  always_comb begin
    word        = ue;
    last_idx    = '0;
    has_report  = 1'b1;
    report_byte = 8'h00;
    unique case (mode_r)
      pictl_pkg::MODE_NONE: begin
        has_report = 1'b0;
      end
      pictl_pkg::MODE_A: report_byte = a_r;
      pictl_pkg::MODE_B: report_byte = b_r;
      pictl_pkg::MODE_INTEG, pictl_pkg::MODE_ERR, pictl_pkg::MODE_DRIVE: begin
        if (mode_r == pictl_pkg::MODE_INTEG) begin
          word = integ_r;
        end else if (mode_r == pictl_pkg::MODE_DRIVE) begin
          word = drive_r;
        end
        last_idx    = 4'd1;
        report_byte = cmd.byte_idx[0] ? word[7:0] : word[15:8];
      end
      pictl_pkg::MODE_DUTY: report_byte = duty_r;
      pictl_pkg::MODE_PACKET: begin
        last_idx = pictl_pkg::PKT_LAST_IDX;
        unique case (cmd.byte_idx)
          pictl_pkg::PKT_IDX_A:    report_byte = a_r;
          pictl_pkg::PKT_IDX_B:    report_byte = b_r;
          pictl_pkg::PKT_IDX_EHI:  report_byte = ue[15:8];
          pictl_pkg::PKT_IDX_ELO:  report_byte = ue[7:0];
          pictl_pkg::PKT_IDX_IHI:  report_byte = integ_r[15:8];
          pictl_pkg::PKT_IDX_ILO:  report_byte = integ_r[7:0];
          pictl_pkg::PKT_IDX_DHI:  report_byte = drive_r[15:8];
          pictl_pkg::PKT_IDX_DLO:  report_byte = drive_r[7:0];
          pictl_pkg::PKT_IDX_DUTY: report_byte = duty_r;
          pictl_pkg::PKT_LAST_IDX:
            report_byte = pictl_pkg::PKT_HDR ^ a_r ^ ue[7:0] ^ duty_r;
          default: report_byte = pictl_pkg::PKT_HDR;
        endcase
      end
      default: ;
    endcase
  end

  assign last           = (cmd.byte_idx == last_idx);
  assign stat.last_byte = last;
  assign duty           = duty_r;

endmodule
